// File: hdl/pcsa_pkg.sv
// Package for the per-CPU slot allocator.
// Holds command, status and state codes and the packed result layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcsa_pkg;

  // Number of CPUs served by the slot table.
  localparam int NUM_CPUS = 16;
  // Most results that one combine transaction emits.
  localparam int MAX_RESULTS = 16;

  // Commands carried on the input stream.
  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_TOUCH   = 2'd1,
    CMD_COMBINE = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_NOTHING = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_LOOKUP  = 2'd1,
    S_COMBINE = 2'd2
  } state_t;

  // Result word as it sits in out_tdata, lowest bit last in this list.
  typedef struct packed {
    logic       pad;
    logic       needs_init;
    status_t    status;
    logic [3:0] slot;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/pcsa_find_first.sv
// Lowest-set-bit search used by the per-CPU slot allocator.
// Shared between free-slot claims and the combine walk. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pcsa_find_first #(
  parameter int WIDTH = 16
) (
  input  wire logic [WIDTH-1:0]                        vec,
  output logic                                         found,
  output logic [((WIDTH > 1) ? $clog2(WIDTH) : 1)-1:0] idx
);

  localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // Priority encoder: scanning from the top leaves the lowest set bit.
  always_comb begin
    found = |vec;
    idx   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/per_cpu_slot_allocator.sv
// Per-CPU slot allocator: top level with the CPU slot table memory and control.
// Depends on pcsa_pkg and pcsa_find_first.
//
// Usage:
//   Commands arrive on the in_ stream (acquire, touch, combine, release) and
//   results leave on the out_ stream. A transaction is accepted when tvalid
//   and tready are both high at a rising clock edge.
//   The slot number each CPU holds lives in a 16-entry synchronous memory
//   with a registered read; per-CPU held bits and the taken and initialized
//   maps are flip-flops.
//   Acquire, touch and release go through the accept cycle, which issues the
//   table read, and the lookup state, which does the read-modify-write and
//   loads the output register when free; no command is accepted meanwhile.
//   Combine walks the initialized map with the shared lowest-set-bit search
//   and emits one result per cycle while the receiver does not stall, up to
//   16 results and at least one, then returns to idle.
//   The block works on one command at a time; the next command is accepted
//   while the last result still waits in the output register.
//   When the receiver stalls, the result holds in the output register and
//   the block waits before loading another one.
//   Reset (rst_n low, synchronous) frees all slots, clears all held and
//   initialized marks and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module per_cpu_slot_allocator
  import pcsa_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // in_tdata: cmd[1:0], cpu_id[5:2], slot_index[9:6], zero[15:10]
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [15:0] in_tdata,
  // out_tdata: slot_out[3:0], status[5:4], needs_init[6], zero[7]
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS);

  // Control and payload registers.
  state_t                state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [3:0]            cpu_r;
  logic [3:0]            sidx_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [NUM_CPUS-1:0]   held_r, held_nxt;
  logic [NUM_SLOTS-1:0]  taken_r, taken_nxt;
  logic [NUM_SLOTS-1:0]  ready_r, ready_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  // Slot table memory and its registered read data.
  logic [SLOT_W-1:0]     slot_mem [NUM_CPUS];
  logic [SLOT_W-1:0]     rd_slot_r;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_wdata;

  logic                  in_acc;
  logic                  out_free;
  logic [NUM_SLOTS-1:0]  search_vec;
  logic                  ff_found;
  logic [SLOT_W-1:0]     ff_idx;
  logic [SLOT_W+3:0]     sidx_ext;
  logic [SLOT_W-1:0]     touch_idx;
  logic                  touch_in_range;
  logic [SLOT_W+3:0]     ff_ext;
  logic [SLOT_W+3:0]     rd_ext;
  logic [NUM_SLOTS-1:0]  ff_onehot;
  logic                  comb_last;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // One search unit: free slots for acquire, initialized slots for combine.
  assign search_vec = (state_r == S_COMBINE) ? ready_r : ~taken_r;

  pcsa_find_first #(
    .WIDTH (NUM_SLOTS)
  ) u_find_first (
    .vec   (search_vec),
    .found (ff_found),
    .idx   (ff_idx)
  );

  // Slot number conversions between the 4-bit fields and SLOT_W bits.
  assign sidx_ext       = {{SLOT_W{1'b0}}, sidx_r};
  assign touch_idx      = sidx_ext[SLOT_W-1:0];
  assign touch_in_range = (32'(sidx_r) < NUM_SLOTS);
  assign ff_ext         = {4'b0000, ff_idx};
  assign rd_ext         = {4'b0000, rd_slot_r};
  assign ff_onehot      = NUM_SLOTS'(1) << ff_idx;
  assign comb_last      = (count_r == CNT_W'(MAX_RESULTS - 1)) ||
                          ((ready_r & ~ff_onehot) == '0);

  // Next state, table updates and result generation.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    held_nxt      = held_r;
    taken_nxt     = taken_r;
    ready_nxt     = ready_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wdata     = ff_idx;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          count_nxt = '0;
          if (cmd_t'(in_tdata[1:0]) == CMD_COMBINE) begin
            state_nxt = S_COMBINE;
          end else begin
            state_nxt = S_LOOKUP;
          end
        end
      end

      S_LOOKUP: begin
        if (out_free) begin
          state_nxt              = S_IDLE;
          out_valid_nxt          = 1'b1;
          out_last_nxt           = 1'b1;
          out_data_nxt           = '0;
          out_data_nxt.status    = ST_OK;
          case (cmd_r)
            CMD_ACQUIRE: begin
              if (held_r[cpu_r]) begin
                out_data_nxt.slot = rd_ext[3:0];
              end else if (!ff_found) begin
                out_data_nxt.status = ST_NO_FREE;
              end else begin
                out_data_nxt.slot = ff_ext[3:0];
                taken_nxt[ff_idx] = 1'b1;
                held_nxt[cpu_r]   = 1'b1;
                mem_we            = 1'b1;
                mem_wdata         = ff_idx;
              end
            end
            CMD_TOUCH: begin
              out_data_nxt.slot = sidx_r;
              if (!touch_in_range) begin
                out_data_nxt.status = ST_NOTHING;
              end else begin
                out_data_nxt.needs_init = !ready_r[touch_idx];
                ready_nxt[touch_idx]    = 1'b1;
              end
            end
            CMD_RELEASE: begin
              if (!held_r[cpu_r]) begin
                out_data_nxt.status = ST_NOTHING;
              end else begin
                out_data_nxt.slot    = rd_ext[3:0];
                taken_nxt[rd_slot_r] = 1'b0;
                held_nxt[cpu_r]      = 1'b0;
              end
            end
            default: begin
              out_data_nxt.status = ST_NOTHING;
            end
          endcase
        end
      end

      S_COMBINE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (!ff_found) begin
            // Nothing initialized: a single empty result ends the transaction.
            out_data_nxt.status = ST_NOTHING;
            out_last_nxt        = 1'b1;
            state_nxt           = S_IDLE;
          end else begin
            out_data_nxt.status = ST_OK;
            out_data_nxt.slot   = ff_ext[3:0];
            out_last_nxt        = comb_last;
            ready_nxt[ff_idx]   = 1'b0;
            count_nxt           = count_r + CNT_W'(1);
            if (comb_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      held_r      <= '0;
      taken_r     <= '0;
      ready_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      taken_r     <= taken_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: the accepted command and the output result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= cmd_t'(in_tdata[1:0]);
      cpu_r  <= in_tdata[5:2];
      sidx_r <= in_tdata[9:6];
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Slot table write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[cpu_r] <= mem_wdata;
    end
  end

  // Slot table read port, issued with the accepted command.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_slot_r <= slot_mem[in_tdata[5:2]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Every held CPU entry accounts for exactly one taken slot.
  a_held_matches_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(held_r) == $countones(taken_r))
    else $error("held CPU count differs from taken slot count");

  // A new result only appears from a working state.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && out_free) |-> (state_r == S_LOOKUP || state_r == S_COMBINE))
    else $error("result loaded while idle");

  // Results that are not last come only from a successful combine step.
  a_mid_combine_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_data_r.status == ST_OK && !out_data_r.needs_init))
    else $error("non-final result with bad status");

endmodule

`default_nettype wire
